/* src/assert_macros.svh */
// Assertion macros used by the top RTL file of the alarm escalator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define SWAE_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swae assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SWAE_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swae assertion failed");

`else

`define SWAE_ASSERT_NOW(lbl, ck, rst_n, ante, cons)
`define SWAE_ASSERT_NEXT(lbl, ck, rst_n, ante, cons)

`endif

`endif

/* src/swae_pkg.sv */
// Types, register indexes and reset constants of the sensor window alarm escalator.
package swae_pkg;

	typedef enum logic [1:0] {
		MOOD_OK    = 2'd0,
		MOOD_ALARM = 2'd1,
		MOOD_CRIT  = 2'd2
	} mood_t;

	typedef enum logic [2:0] {
		REG_TEMP_LOW    = 3'd0,
		REG_TEMP_HIGH   = 3'd1,
		REG_HUMID_LOW   = 3'd2,
		REG_HUMID_HIGH  = 3'd3,
		REG_SOIL_LOW    = 3'd4,
		REG_SOIL_HIGH   = 3'd5,
		REG_LIGHT_NEED  = 3'd6,
		REG_ESCALATE    = 3'd7
	} reg_index_t;

	localparam logic [31:0] DEBOUNCE_MS_DEF        = 32'd300000;
	localparam logic [7:0]  ALARM_DARK_DAYS_DEF    = 8'd1;
	localparam logic [7:0]  CRITICAL_DARK_DAYS_DEF = 8'd2;

	localparam logic signed [11:0] TEMP_LOW_RST  = 12'sd150;
	localparam logic signed [11:0] TEMP_HIGH_RST = 12'sd300;
	localparam logic [9:0]  HUMID_LOW_RST  = 10'd300;
	localparam logic [9:0]  HUMID_HIGH_RST = 10'd800;
	localparam logic [9:0]  SOIL_LOW_RST   = 10'd200;
	localparam logic [9:0]  SOIL_HIGH_RST  = 10'd800;
	localparam logic [26:0] LIGHT_NEED_RST = 27'd28800000;
	localparam logic [31:0] ESCALATE_RST   = 32'd43200000;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic               sample_valid;
		logic signed [11:0] temperature;
		logic [9:0]         humidity;
		logic [9:0]         moisture;
		logic               light_seen;
		logic               link_up;
		logic               clock_synced;
		logic [8:0]         day_of_year;
	} smp_t;

	typedef struct packed {
		logic [1:0] mood;
		logic       all_good;
		logic [7:0] dark_days;
	} rpt_t;

	typedef struct packed {
		logic signed [11:0] temp_low;
		logic signed [11:0] temp_high;
		logic [9:0]         humid_low;
		logic [9:0]         humid_high;
		logic [9:0]         soil_low;
		logic [9:0]         soil_high;
		logic [26:0]        light_need_ms;
		logic [31:0]        escalate_ms;
	} cfg_t;

endpackage

/* src/swae_step.sv */
// State registers and per-sample update logic: light tracking, window checks and mood machine.
module swae_step #(
	parameter logic [31:0] DEBOUNCE_MS        = swae_pkg::DEBOUNCE_MS_DEF,
	parameter logic [7:0]  ALARM_DARK_DAYS    = swae_pkg::ALARM_DARK_DAYS_DEF,
	parameter logic [7:0]  CRITICAL_DARK_DAYS = swae_pkg::CRITICAL_DARK_DAYS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  swae_pkg::smp_t  smp,
	input  swae_pkg::cfg_t  cfg,
	output swae_pkg::rpt_t  rpt
);

	swae_pkg::mood_t mood_q, mood_n;
	logic        last_good_q;
	logic [31:0] change_stamp_q;
	logic        timer_on_q, timer_on_n;
	logic [31:0] timer_stamp_q, timer_stamp_n;
	logic        light_started_q, light_started_n;
	logic        day_known_q, day_known_n;
	logic [8:0]  last_day_q, last_day_n;
	logic [7:0]  dark_q, dark_n;
	logic [31:0] light_accum_q, light_accum_n;
	logic [31:0] light_stamp_q, light_stamp_n;

	logic        good, settled, changed, upd;
	logic [31:0] change_stamp_n;

	assign upd = en && smp.sample_valid;

	// Light tracking; only runs while the link is up.
	always_comb begin
		logic [31:0] base_stamp;
		logic [31:0] accum_base;
		logic [32:0] sum;
		logic        day_change;
		base_stamp      = light_started_q ? light_stamp_q : smp.now_ms;
		day_change      = day_known_q && (smp.day_of_year != last_day_q);
		accum_base      = day_change ? 32'd0 : light_accum_q;
		sum             = {1'b0, accum_base} + {1'b0, smp.now_ms - base_stamp};
		light_started_n = light_started_q;
		light_stamp_n   = light_stamp_q;
		day_known_n     = day_known_q;
		last_day_n      = last_day_q;
		dark_n          = dark_q;
		light_accum_n   = light_accum_q;
		if (smp.link_up) begin
			light_started_n = 1'b1;
			light_stamp_n   = base_stamp;
			if (smp.clock_synced) begin
				if (day_change) begin
					if (light_accum_q < {5'd0, cfg.light_need_ms}) begin
						if (dark_q != 8'hFF) begin
							dark_n = dark_q + 8'd1;
						end
					end else begin
						dark_n = 8'd0;
					end
					last_day_n = smp.day_of_year;
				end else if (!day_known_q) begin
					last_day_n  = smp.day_of_year;
					day_known_n = 1'b1;
				end
				light_accum_n = accum_base;
				if (smp.light_seen) begin
					light_accum_n = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end
				light_stamp_n = smp.now_ms;
			end
		end
	end

	// Combined condition and debounce.
	always_comb begin
		logic sens_ok;
		logic light_ok;
		sens_ok = ($signed(smp.temperature) >= $signed(cfg.temp_low)) &&
			($signed(smp.temperature) <= $signed(cfg.temp_high)) &&
			(smp.humidity >= cfg.humid_low) && (smp.humidity <= cfg.humid_high) &&
			(smp.moisture >= cfg.soil_low) && (smp.moisture <= cfg.soil_high);
		light_ok       = !light_started_n || (dark_n < ALARM_DARK_DAYS);
		good           = sens_ok && light_ok;
		changed        = good != last_good_q;
		change_stamp_n = changed ? smp.now_ms : change_stamp_q;
		settled        = (smp.now_ms - change_stamp_n) >= DEBOUNCE_MS;
	end

	// Mood machine: next state.
	always_comb begin
		logic expired;
		logic too_dark;
		expired  = timer_on_q && ((smp.now_ms - timer_stamp_q) >= cfg.escalate_ms);
		too_dark = light_started_n && (dark_n >= CRITICAL_DARK_DAYS);
		mood_n   = mood_q;
		unique case (mood_q)
			swae_pkg::MOOD_OK: begin
				if (!good && settled) begin
					mood_n = swae_pkg::MOOD_ALARM;
				end
			end
			swae_pkg::MOOD_ALARM: begin
				if (good && settled) begin
					mood_n = swae_pkg::MOOD_OK;
				end else if (!good && (expired || too_dark)) begin
					mood_n = swae_pkg::MOOD_CRIT;
				end
			end
			default: begin
				// Critical, and the unused code treated as critical.
				if (good && settled) begin
					mood_n = swae_pkg::MOOD_OK;
				end
			end
		endcase
	end

	// Mood machine: escalation timer control.
	always_comb begin
		timer_on_n    = timer_on_q;
		timer_stamp_n = timer_stamp_q;
		unique case (mood_q)
			swae_pkg::MOOD_OK: begin
				if (!good && settled && !timer_on_q) begin
					timer_on_n    = 1'b1;
					timer_stamp_n = smp.now_ms;
				end
			end
			default: begin
				if (good && settled) begin
					timer_on_n = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mood_q          <= swae_pkg::MOOD_OK;
			last_good_q     <= 1'b1;
			change_stamp_q  <= 32'd0;
			timer_on_q      <= 1'b0;
			timer_stamp_q   <= 32'd0;
			light_started_q <= 1'b0;
			day_known_q     <= 1'b0;
			last_day_q      <= 9'd0;
			dark_q          <= 8'd0;
			light_accum_q   <= 32'd0;
			light_stamp_q   <= 32'd0;
		end else if (upd) begin
			mood_q          <= mood_n;
			last_good_q     <= good;
			change_stamp_q  <= change_stamp_n;
			timer_on_q      <= timer_on_n;
			timer_stamp_q   <= timer_stamp_n;
			light_started_q <= light_started_n;
			day_known_q     <= day_known_n;
			last_day_q      <= last_day_n;
			dark_q          <= dark_n;
			light_accum_q   <= light_accum_n;
			light_stamp_q   <= light_stamp_n;
		end
	end

	// An invalid sample reports the held state unchanged.
	always_comb begin
		if (smp.sample_valid) begin
			rpt.mood      = mood_n;
			rpt.all_good  = good;
			rpt.dark_days = dark_n;
		end else begin
			rpt.mood      = mood_q;
			rpt.all_good  = last_good_q;
			rpt.dark_days = dark_q;
		end
	end

endmodule

/* src/sensor_window_alarm_escalator_top.sv */
// An accepted item is registered in smp_s1; its result from swae_step is then registered in rpt_q.
// One item per cycle while the output is not stalled; swae_step works out its next state combinationally.
// A waiting result holds the item in the input register, so the input stalls only once
// that register is full as well. arst_n clears all state and loads the default thresholds.
// Configuration writes are always taken (cfg_ready stays high).
`include "assert_macros.svh"

module sensor_window_alarm_escalator_top #(
	parameter logic [31:0] DEBOUNCE_MS        = swae_pkg::DEBOUNCE_MS_DEF,
	parameter logic [7:0]  ALARM_DARK_DAYS    = swae_pkg::ALARM_DARK_DAYS_DEF,
	parameter logic [7:0]  CRITICAL_DARK_DAYS = swae_pkg::CRITICAL_DARK_DAYS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           smp_valid,
	output logic           smp_stall,
	input  swae_pkg::smp_t smp,
	output logic           rpt_valid,
	input  logic           rpt_stall,
	output swae_pkg::rpt_t rpt,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data
);

	swae_pkg::smp_t smp_s1;
	logic           smp_valid_s1;
	swae_pkg::rpt_t rpt_q, rpt_n;
	logic           rpt_valid_q;
	swae_pkg::cfg_t cfg_q;
	logic           advance;

	assign cfg_ready = 1'b1;
	assign advance   = !rpt_valid_q || !rpt_stall;
	assign smp_stall = smp_valid_s1 && !advance;
	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_low      <= swae_pkg::TEMP_LOW_RST;
			cfg_q.temp_high     <= swae_pkg::TEMP_HIGH_RST;
			cfg_q.humid_low     <= swae_pkg::HUMID_LOW_RST;
			cfg_q.humid_high    <= swae_pkg::HUMID_HIGH_RST;
			cfg_q.soil_low      <= swae_pkg::SOIL_LOW_RST;
			cfg_q.soil_high     <= swae_pkg::SOIL_HIGH_RST;
			cfg_q.light_need_ms <= swae_pkg::LIGHT_NEED_RST;
			cfg_q.escalate_ms   <= swae_pkg::ESCALATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (swae_pkg::reg_index_t'(cfg_index))
				swae_pkg::REG_TEMP_LOW:   cfg_q.temp_low      <= $signed(cfg_data[11:0]);
				swae_pkg::REG_TEMP_HIGH:  cfg_q.temp_high     <= $signed(cfg_data[11:0]);
				swae_pkg::REG_HUMID_LOW:  cfg_q.humid_low     <= cfg_data[9:0];
				swae_pkg::REG_HUMID_HIGH: cfg_q.humid_high    <= cfg_data[9:0];
				swae_pkg::REG_SOIL_LOW:   cfg_q.soil_low      <= cfg_data[9:0];
				swae_pkg::REG_SOIL_HIGH:  cfg_q.soil_high     <= cfg_data[9:0];
				swae_pkg::REG_LIGHT_NEED: cfg_q.light_need_ms <= cfg_data[26:0];
				swae_pkg::REG_ESCALATE:   cfg_q.escalate_ms   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid_s1 <= 1'b0;
		end else if (!smp_stall) begin
			smp_valid_s1 <= smp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!smp_stall && smp_valid) begin
			smp_s1 <= smp;
		end
	end

	swae_step #(
		.DEBOUNCE_MS        (DEBOUNCE_MS),
		.ALARM_DARK_DAYS    (ALARM_DARK_DAYS),
		.CRITICAL_DARK_DAYS (CRITICAL_DARK_DAYS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (smp_valid_s1 && advance),
		.smp    (smp_s1),
		.cfg    (cfg_q),
		.rpt    (rpt_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (advance) begin
			rpt_valid_q <= smp_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && smp_valid_s1) begin
			rpt_q <= rpt_n;
		end
	end

	// A blocked result with a full input stage must hold off the upstream side.
	`SWAE_ASSERT_NOW(a_full_stalls, clk, arst_n, smp_valid_s1 && rpt_valid_q && rpt_stall, smp_stall)
	// An accepted item always lands in the input stage.
	`SWAE_ASSERT_NEXT(a_accept_lands, clk, arst_n, smp_valid && !smp_stall, smp_valid_s1)
	// A taken result with nothing behind it leaves the output empty.
	`SWAE_ASSERT_NEXT(a_out_drains, clk, arst_n, rpt_valid_q && !rpt_stall && !smp_valid_s1, !rpt_valid_q)

endmodule

/* test/tb_sensor_window_alarm_escalator_top.sv */
// Self-checking testbench for the sensor window alarm escalator: random and directed samples.
module tb_sensor_window_alarm_escalator_top;
	import swae_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        smp_valid = 1'b0;
	logic        smp_stall;
	smp_t        smp = '0;
	logic        rpt_valid;
	logic        rpt_stall = 1'b0;
	rpt_t        rpt;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_TEMP_LOW;
	logic [31:0] cfg_data = '0;

	sensor_window_alarm_escalator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp),
		.rpt_valid (rpt_valid),
		.rpt_stall (rpt_stall),
		.rpt       (rpt),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	smp_t queued_samples[$];
	rpt_t pending_reports[$];
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   fail_count = 0;

	// Thresholds as the block holds them, starting from the reset defaults.
	cfg_t cur_cfg = '{temp_low: TEMP_LOW_RST, temp_high: TEMP_HIGH_RST,
		humid_low: HUMID_LOW_RST, humid_high: HUMID_HIGH_RST,
		soil_low: SOIL_LOW_RST, soil_high: SOIL_HIGH_RST,
		light_need_ms: LIGHT_NEED_RST, escalate_ms: ESCALATE_RST};

	mood_t       plant_mood = MOOD_OK;
	logic        plant_last_good = 1'b1;
	logic [31:0] plant_change_stamp = '0;
	logic        plant_timer_on = 1'b0;
	logic [31:0] plant_timer_stamp = '0;
	logic        plant_light_started = 1'b0;
	logic        plant_day_known = 1'b0;
	logic [8:0]  plant_last_day = '0;
	logic [7:0]  plant_dark_count = '0;
	logic [31:0] plant_light_accum = '0;
	logic [31:0] plant_light_stamp = '0;

	// Stimulus generator state.
	logic [31:0] gen_now = '0;
	logic [8:0]  gen_day = 9'd100;
	bit          gen_bright = 1'b1;
	bit          run_good = 1'b1;
	int          run_left = 0;

	function automatic rpt_t advance_alarm(smp_t s);
		logic        good, sens_ok, light_ok, settled, expired, too_dark;
		logic [31:0] delta;
		logic [32:0] sum;
		rpt_t        r;
		if (s.sample_valid) begin
			if (s.link_up) begin
				if (!plant_light_started) begin
					plant_light_started = 1'b1;
					plant_light_stamp = s.now_ms;
				end
				if (s.clock_synced) begin
					if (plant_day_known && s.day_of_year != plant_last_day) begin
						if (plant_light_accum < {5'd0, cur_cfg.light_need_ms}) begin
							if (plant_dark_count != 8'd255)
								plant_dark_count = plant_dark_count + 8'd1;
						end else begin
							plant_dark_count = '0;
						end
						plant_light_accum = '0;
						plant_last_day = s.day_of_year;
					end else if (!plant_day_known) begin
						plant_last_day = s.day_of_year;
						plant_day_known = 1'b1;
					end
					if (s.light_seen) begin
						delta = s.now_ms - plant_light_stamp;
						sum = {1'b0, plant_light_accum} + {1'b0, delta};
						plant_light_accum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					end
					plant_light_stamp = s.now_ms;
				end
			end

			sens_ok = $signed(s.temperature) >= $signed(cur_cfg.temp_low) &&
				$signed(s.temperature) <= $signed(cur_cfg.temp_high) &&
				s.humidity >= cur_cfg.humid_low && s.humidity <= cur_cfg.humid_high &&
				s.moisture >= cur_cfg.soil_low && s.moisture <= cur_cfg.soil_high;
			light_ok = !plant_light_started || plant_dark_count < ALARM_DARK_DAYS_DEF;
			good = sens_ok && light_ok;

			if (good != plant_last_good) begin
				plant_last_good = good;
				plant_change_stamp = s.now_ms;
			end
			delta = s.now_ms - plant_change_stamp;
			settled = delta >= DEBOUNCE_MS_DEF;

			case (plant_mood)
				MOOD_OK: begin
					if (!good && settled) begin
						plant_mood = MOOD_ALARM;
						if (!plant_timer_on) begin
							plant_timer_on = 1'b1;
							plant_timer_stamp = s.now_ms;
						end
					end
				end
				MOOD_ALARM: begin
					if (good && settled) begin
						plant_mood = MOOD_OK;
						plant_timer_on = 1'b0;
					end else if (!good) begin
						delta = s.now_ms - plant_timer_stamp;
						expired = plant_timer_on && delta >= cur_cfg.escalate_ms;
						too_dark = plant_light_started &&
							plant_dark_count >= CRITICAL_DARK_DAYS_DEF;
						if (expired || too_dark)
							plant_mood = MOOD_CRIT;
					end
				end
				default: begin
					// Any other code behaves as critical.
					if (good && settled) begin
						plant_mood = MOOD_OK;
						plant_timer_on = 1'b0;
					end
				end
			endcase
		end else begin
			good = plant_last_good;
		end
		r.mood = plant_mood;
		r.all_good = good;
		r.dark_days = plant_dark_count;
		return r;
	endfunction

	// Sample driver: presents queued items and predicts each one that is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (smp_valid && !smp_stall)
				pending_reports.push_back(advance_alarm(smp));
			if (!smp_valid || !smp_stall) begin
				if (queued_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					smp <= queued_samples.pop_front();
					smp_valid <= 1'b1;
				end else begin
					smp_valid <= 1'b0;
				end
			end
		end
	end

	// Report monitor: checks each accepted item against the oldest prediction.
	always @(posedge clk) begin
		rpt_t want;
		if (arst_n) begin
			if (rpt_valid && !rpt_stall) begin
				if (pending_reports.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected report, expected none, actual mood %0d good %0d dark %0d",
						$time, rpt.mood, rpt.all_good, rpt.dark_days);
				end else begin
					want = pending_reports.pop_front();
					if (rpt.mood !== want.mood) begin
						fail_count++;
						$display("%0t: mood expected %0d actual %0d", $time, want.mood, rpt.mood);
					end
					if (rpt.all_good !== want.all_good) begin
						fail_count++;
						$display("%0t: all_good expected %0d actual %0d",
							$time, want.all_good, rpt.all_good);
					end
					if (rpt.dark_days !== want.dark_days) begin
						fail_count++;
						$display("%0t: dark_days expected %0d actual %0d",
							$time, want.dark_days, rpt.dark_days);
					end
				end
			end
			rpt_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	task automatic push_item(logic [31:0] now, bit valid, int temp, int hum, int soil,
		bit seen, bit link, bit synced, int day);
		smp_t s;
		s.now_ms = now;
		s.sample_valid = valid;
		s.temperature = 12'(temp);
		s.humidity = 10'(hum);
		s.moisture = 10'(soil);
		s.light_seen = seen;
		s.link_up = link;
		s.clock_synced = synced;
		s.day_of_year = 9'(day);
		queued_samples.push_back(s);
	endtask

	// Picks a value at or inside a threshold window, or just or further outside it.
	function automatic int window_value(int lo, int hi, bit in_win);
		case ($urandom_range(0, 3))
			0: return in_win ? lo : lo - 1;
			1: return in_win ? hi : hi + 1;
			default: begin
				if (in_win)
					return (lo <= hi) ? lo + int'($urandom_range(0, hi - lo)) : lo;
				return $urandom_range(0, 1) ? lo - 1 - int'($urandom_range(0, 300))
					: hi + 1 + int'($urandom_range(0, 300));
			end
		endcase
	endfunction

	task automatic gen_random_items(int count);
		smp_t        s;
		int          sel, out_f;
		logic [95:0] raw;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 19);
			if (sel < 8)
				gen_now += $urandom_range(0, 20000);
			else if (sel < 14)
				gen_now += $urandom_range(20000, 600000);
			else if (sel < 18)
				gen_now += $urandom_range(600000, 30000000);
			else if (sel < 19)
				gen_now += $urandom_range(30000000, 90000000);
			else
				gen_now += $urandom;
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 9) == 0)
					gen_day = 9'($urandom);
				else
					gen_day = (gen_day >= 9'd365) ? 9'd0 : gen_day + 9'd1;
				gen_bright = $urandom_range(0, 1);
			end
			// Long runs of good or bad conditions let the debounce settle.
			if (run_left == 0) begin
				run_good = !run_good;
				run_left = $urandom_range(2, 25);
			end
			run_left--;
			out_f = run_good ? 3 : $urandom_range(0, 2);
			s.now_ms = gen_now;
			s.sample_valid = ($urandom_range(0, 11) != 0);
			s.temperature = 12'(window_value(int'($signed(cur_cfg.temp_low)),
				int'($signed(cur_cfg.temp_high)), out_f != 0));
			s.humidity = 10'(window_value(int'(cur_cfg.humid_low),
				int'(cur_cfg.humid_high), out_f != 1));
			s.moisture = 10'(window_value(int'(cur_cfg.soil_low),
				int'(cur_cfg.soil_high), out_f != 2));
			s.light_seen = gen_bright ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0);
			s.link_up = ($urandom_range(0, 7) != 0);
			s.clock_synced = ($urandom_range(0, 7) != 0);
			s.day_of_year = gen_day;
			if ($urandom_range(0, 9) == 0) begin
				raw = {$urandom, $urandom, $urandom};
				s = raw[$bits(smp_t)-1:0];
				s.now_ms = gen_now;
			end
			queued_samples.push_back(s);
		end
	endtask

	task automatic write_all_regs(cfg_t c);
		logic [31:0] vals [8];
		int          widths [8];
		logic [31:0] mask;
		reg_index_t  ri;
		vals = '{32'(c.temp_low), 32'(c.temp_high), 32'(c.humid_low), 32'(c.humid_high),
			32'(c.soil_low), 32'(c.soil_high), 32'(c.light_need_ms), c.escalate_ms};
		widths = '{12, 12, 10, 10, 10, 10, 27, 32};
		ri = ri.first();
		repeat (ri.num()) begin
			mask = (widths[ri] == 32) ? 32'hFFFF_FFFF : ((32'd1 << widths[ri]) - 32'd1);
			// Bits above the register width carry noise that the block must drop.
			cfg_index <= ri;
			cfg_data <= (vals[ri] & mask) | ($urandom & ~mask);
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			ri = ri.next();
		end
		cfg_valid <= 1'b0;
		cur_cfg = c;
	endtask

	function automatic cfg_t make_cfg(int tl, int th, int hl, int hh, int sl, int sh,
		logic [31:0] need, logic [31:0] esc);
		cfg_t c;
		c.temp_low = 12'(tl);
		c.temp_high = 12'(th);
		c.humid_low = 10'(hl);
		c.humid_high = 10'(hh);
		c.soil_low = 10'(sl);
		c.soil_high = 10'(sh);
		c.light_need_ms = 27'(need);
		c.escalate_ms = esc;
		return c;
	endfunction

	task automatic wait_drained();
		do
			@(posedge clk);
		while (queued_samples.size() != 0 || smp_valid || pending_reports.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(cfg_t c, int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		write_all_regs(c);
		gen_random_items(100);
		wait_drained();
	endtask

	initial begin
		int tl, th, hl, hh, sl, sh;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through light tracking, day changes and escalation.
		push_item(32'd1000, 0, 0, 0, 0, 1, 1, 1, 5);
		push_item(32'd2000, 1, 200, 500, 500, 1, 0, 1, 10);
		push_item(32'd3000, 1, 200, 500, 500, 1, 1, 0, 10);
		push_item(32'd4000, 1, 200, 500, 500, 1, 1, 1, 10);
		push_item(32'd32404000, 1, 200, 500, 500, 1, 1, 1, 10);
		push_item(32'd32500000, 1, 200, 500, 500, 0, 1, 1, 11);
		push_item(32'd40000000, 1, 200, 500, 500, 0, 1, 1, 12);
		push_item(32'd40400000, 1, 200, 500, 500, 0, 1, 1, 12);
		push_item(32'd41000000, 1, 200, 500, 500, 0, 1, 1, 13);
		push_item(32'd41100000, 1, -400, 500, 500, 0, 1, 1, 13);
		push_item(32'd41200000, 1, 1250, 500, 500, 0, 1, 1, 13);
		push_item(32'd41300000, 1, -2048, 500, 500, 0, 1, 1, 13);
		push_item(32'd41400000, 1, 2047, 500, 500, 0, 1, 1, 13);
		push_item(32'd41500000, 1, 200, 0, 500, 0, 1, 1, 13);
		push_item(32'd41600000, 1, 200, 1000, 500, 0, 1, 1, 13);
		push_item(32'd41700000, 1, 200, 1023, 1023, 0, 1, 1, 13);
		push_item(32'd41800000, 1, 200, 500, 0, 1, 1, 1, 13);
		push_item(32'd41900000, 1, 200, 500, 1000, 1, 1, 1, 13);
		push_item(32'd42000000, 1, 200, 500, 500, 1, 1, 1, 500);
		push_item(32'hFFFF_FF00, 1, 200, 500, 500, 1, 1, 1, 500);
		push_item(32'h0000_1000, 1, 200, 500, 500, 1, 1, 1, 511);
		push_item(32'h0005_0000, 0, -2048, 1023, 1023, 1, 1, 1, 511);
		gen_now = 32'h0005_0000;
		wait_drained();

		run_phase(make_cfg(-400, 1250, 0, 1000, 0, 1000, 32'd0, 32'd1), 0, 0);
		run_phase(make_cfg(150, 300, 300, 800, 200, 800, 32'd86400000, 32'd600000), 85, 0);
		run_phase(make_cfg(250, 250, 500, 500, 1000, 1000, 32'h07FF_FFFF, 32'hFFFF_FFFF),
			0, 85);
		tl = -400 + int'($urandom_range(0, 1650));
		th = tl + int'($urandom_range(0, 1250 - tl));
		hl = $urandom_range(0, 1000);
		hh = hl + int'($urandom_range(0, 1000 - hl));
		sl = $urandom_range(0, 1000);
		sh = sl + int'($urandom_range(0, 1000 - sl));
		run_phase(make_cfg(tl, th, hl, hh, sl, sh, $urandom_range(0, 86400000),
			$urandom_range(1, 50000000)), 25, 25);
		// Inverted windows keep every sample bad; a zero timer escalates at once.
		run_phase(make_cfg(1250, -400, 1000, 0, 0, 1000, 32'd28800000, 32'd0), 0, 0);

		if (pending_reports.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* sensor_window_alarm_escalator_top.f */
+incdir+src
src/swae_pkg.sv
src/swae_step.sv
src/sensor_window_alarm_escalator_top.sv
test/tb_sensor_window_alarm_escalator_top.sv
